// ===== rtl/jdc_pkg.sv =====
// Shared widths, constants, types and tables for the Julian date converter.
`timescale 1ns / 1ps

package jdc_pkg;

  // Fixed-point input format.
  localparam int FRAC_BITS = 32;
  localparam int JD_W      = 63;
  localparam int SUM_W     = 64;

  // Result field widths.
  localparam int YEAR_W  = 24;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  // Pipeline: stage 0 is the input register, the last stage feeds the output register.
  localparam int LAST_STAGE = 8;

  // Day arithmetic widths.
  localparam int L0_W   = 32;
  localparam int REM_W  = 34;
  localparam int N_W    = 16;
  localparam int L1_W   = 16;
  localparam int X_W    = 17;
  localparam int IP_W   = 29;
  localparam int I_W    = 7;
  localparam int L2_W   = 10;
  localparam int JP_W   = 22;
  localparam int JE_W   = 6;
  localparam int RJ_W   = 18;
  localparam int J_W    = 4;
  localparam int YR_W   = 25;

  // Time-of-day widths.
  localparam int TP_W    = FRAC_BITS + 10;
  localparam int SECS_W  = 17;
  localparam int MPROD_W = 36;
  localparam int MINS_W  = 11;
  localparam int HPROD_W = 24;

  localparam logic [31:0] DAY_LIMIT = 32'd2147483647;

  // Fliegel-Van Flandern constants.
  localparam logic [L0_W-1:0] C_OFFSET    = 32'd68569;
  localparam logic [17:0]     C_4CENT     = 18'd146097;
  localparam logic [16:0]     C_N_RECIP   = 17'd117592;   // floor(2^34 / 146097)
  localparam int              C_N_SHIFT   = 32;
  localparam logic [11:0]     C_I_RECIP   = 12'd2870;     // floor(4000 * 2^20 / 1461001)
  localparam int              C_I_SHIFT   = 20;
  localparam logic [11:0]     C_I_MUL     = 12'd4000;
  localparam logic [20:0]     C_I_DIV     = 21'd1461001;
  localparam logic [10:0]     C_4YEAR     = 11'd1461;
  localparam logic [5:0]      C_MAR_OFS   = 6'd31;
  localparam logic [11:0]     C_J_RECIP   = 12'd2142;     // floor(80 * 2^16 / 2447)
  localparam int              C_J_SHIFT   = 16;
  localparam logic [6:0]      C_J_MUL     = 7'd80;
  localparam logic [11:0]     C_J_DIV     = 12'd2447;
  localparam logic [J_W-1:0]  C_J_WRAP    = 4'd11;
  localparam logic [J_W-1:0]  C_MON_BACK  = 4'd10;
  localparam logic [J_W-1:0]  C_MON_FWD   = 4'd2;
  localparam logic [6:0]      C_CENTURY   = 7'd100;
  localparam logic [12:0]     C_YEAR_BASE = 13'd4900;

  // Seconds of day: 86400 = 675 * 128.
  localparam logic [9:0]      C_SEC_MUL   = 10'd675;
  localparam logic [18:0]     C_SEC_RECIP = 19'd279621;   // ceil(2^24 / 60)
  localparam int              C_SEC_SHIFT = 24;
  localparam logic [12:0]     C_MIN_RECIP = 13'd4370;     // ceil(2^18 / 60)
  localparam int              C_MIN_SHIFT = 18;
  localparam logic [5:0]      C_SIXTY     = 6'd60;

  typedef struct packed {
    logic                 ok;
    logic [L0_W-1:0]      l0;
    logic [FRAC_BITS-1:0] frac;
  } jdc_front_t;

  typedef struct packed {
    logic                     ok;
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day;
  } jdc_date_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } jdc_tod_t;

  // floor(2447 * j / 80): days before the start of month index j (March based).
  function automatic logic [8:0] month_start(input logic [J_W-1:0] j);
    logic [8:0] r;
    case (j)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      default: r = 9'd458;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/jdc_front.sv =====
// Input register and split of the Julian date into day number and day fraction.
`timescale 1ns / 1ps

module jdc_front (
  input  logic                    clk,
  input  logic                    en,
  input  logic [jdc_pkg::JD_W-1:0] julian_date,
  output jdc_pkg::jdc_front_t     front
);
  import jdc_pkg::*;

  logic [JD_W-1:0]  jd_r;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] whole;
  jdc_front_t       front_r;
  jdc_front_t       front_nxt;

  // Adding half a day moves the day boundary from noon to midnight.
  always_comb begin
    sum             = {1'b0, jd_r} + (SUM_W'(1) << (FRAC_BITS - 1));
    whole           = sum >> FRAC_BITS;
    front_nxt.ok    = (whole <= SUM_W'(DAY_LIMIT));
    front_nxt.l0    = L0_W'(whole[30:0]) + C_OFFSET;
    front_nxt.frac  = sum[FRAC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      jd_r    <= julian_date;
      front_r <= front_nxt;
    end
  end

  assign front = front_r;

endmodule

// ===== rtl/jdc_date.sv =====
// Day number to Gregorian year, month and day, one constant division per pair of stages.
`timescale 1ns / 1ps

module jdc_date (
  input  logic                clk,
  input  logic                en,
  input  jdc_pkg::jdc_front_t front,
  output jdc_pkg::jdc_date_t  date
);
  import jdc_pkg::*;

  // Stage 2
  logic                   ok2_r;
  logic [L0_W-1:0]        l0_2_r;
  logic [L0_W+16:0]       pn_r, pn_nxt;
  // Stage 3
  logic                   ok3_r;
  logic [N_W-1:0]         n3_r, n3_nxt;
  logic [L1_W-1:0]        l1_3_r, l1_3_nxt;
  // Stage 4
  logic                   ok4_r;
  logic [N_W-1:0]         n4_r;
  logic [L1_W-1:0]        l1_4_r;
  logic [IP_W-1:0]        ip_r, ip_nxt;
  // Stage 5
  logic                   ok5_r;
  logic [N_W-1:0]         n5_r;
  logic [L1_W-1:0]        l1_5_r;
  logic [I_W-1:0]         i5_r, i5_nxt;
  // Stage 6
  logic                   ok6_r;
  logic [N_W-1:0]         n6_r;
  logic [I_W-1:0]         i6_r;
  logic [L2_W-1:0]        l2_6_r, l2_6_nxt;
  // Stage 7
  logic                   ok7_r;
  logic [N_W-1:0]         n7_r;
  logic [I_W-1:0]         i7_r;
  logic [L2_W-1:0]        l2_7_r;
  logic [JP_W-1:0]        jp_r, jp_nxt;
  // Stage 8
  logic                   ok8_r;
  logic [N_W-1:0]         n8_r;
  logic [I_W-1:0]         i8_r;
  logic [L2_W-1:0]        l2_8_r;
  logic [J_W-1:0]         j8_r, j8_nxt;

  logic [N_W-1:0]   n_est;
  logic [REM_W-1:0] n_rem;
  logic [REM_W-1:0] n_rem_fix;
  logic [X_W-1:0]   x3;
  logic [X_W-1:0]   x4;
  logic [I_W-1:0]   i_est;
  logic [IP_W-1:0]  i_rem;
  logic [17:0]      yrs_days;
  logic [L1_W+1:0]  l2_full;
  logic [JE_W-1:0]  j_est;
  logic [RJ_W-1:0]  j_rem;
  logic             l3;
  logic [YR_W-1:0]  yr_full;

  // Each quotient estimate from a reciprocal is exact or one short; the remainder fixes it.
  always_comb begin
    pn_nxt = (L0_W+17)'(front.l0) * (L0_W+17)'(C_N_RECIP);

    n_est  = pn_r[C_N_SHIFT +: N_W];
    n_rem  = {l0_2_r, 2'b00} - REM_W'(n_est) * REM_W'(C_4CENT);
    if (n_rem >= REM_W'(C_4CENT)) begin
      n3_nxt    = n_est + N_W'(1);
      n_rem_fix = n_rem - REM_W'(C_4CENT);
    end else begin
      n3_nxt    = n_est;
      n_rem_fix = n_rem;
    end
    l1_3_nxt = n_rem_fix[L1_W+1:2];

    x3     = X_W'(l1_3_r) + X_W'(1);
    ip_nxt = IP_W'(x3) * IP_W'(C_I_RECIP);

    x4    = X_W'(l1_4_r) + X_W'(1);
    i_est = ip_r[C_I_SHIFT +: I_W];
    i_rem = IP_W'(x4) * IP_W'(C_I_MUL) - IP_W'(i_est) * IP_W'(C_I_DIV);
    if (i_rem >= IP_W'(C_I_DIV)) begin
      i5_nxt = i_est + I_W'(1);
    end else begin
      i5_nxt = i_est;
    end

    yrs_days = (18'(i5_r) * 18'(C_4YEAR)) >> 2;
    l2_full  = (L1_W+2)'(l1_5_r) + (L1_W+2)'(C_MAR_OFS) - (L1_W+2)'(yrs_days);
    l2_6_nxt = l2_full[L2_W-1:0];

    jp_nxt = JP_W'(l2_6_r) * JP_W'(C_J_RECIP);

    j_est = jp_r[C_J_SHIFT +: JE_W];
    j_rem = RJ_W'(l2_7_r) * RJ_W'(C_J_MUL) - RJ_W'(j_est) * RJ_W'(C_J_DIV);
    if (j_rem >= RJ_W'(C_J_DIV)) begin
      j8_nxt = J_W'(j_est + JE_W'(1));
    end else begin
      j8_nxt = J_W'(j_est);
    end
  end

  // Month index runs from March; the last two wrap into the next year.
  always_comb begin
    l3         = (j8_r >= C_J_WRAP);
    date.ok    = ok8_r;
    date.day   = DAY_W'(l2_8_r - L2_W'(month_start(j8_r)));
    date.month = l3 ? (j8_r - C_MON_BACK) : (j8_r + C_MON_FWD);
    yr_full    = YR_W'(n8_r) * YR_W'(C_CENTURY) - YR_W'(C_YEAR_BASE)
                 + YR_W'(i8_r) + YR_W'(l3);
    date.year  = YEAR_W'(yr_full);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok2_r  <= front.ok;
      l0_2_r <= front.l0;
      pn_r   <= pn_nxt;

      ok3_r  <= ok2_r;
      n3_r   <= n3_nxt;
      l1_3_r <= l1_3_nxt;

      ok4_r  <= ok3_r;
      n4_r   <= n3_r;
      l1_4_r <= l1_3_r;
      ip_r   <= ip_nxt;

      ok5_r  <= ok4_r;
      n5_r   <= n4_r;
      l1_5_r <= l1_4_r;
      i5_r   <= i5_nxt;

      ok6_r  <= ok5_r;
      n6_r   <= n5_r;
      i6_r   <= i5_r;
      l2_6_r <= l2_6_nxt;

      ok7_r  <= ok6_r;
      n7_r   <= n6_r;
      i7_r   <= i6_r;
      l2_7_r <= l2_6_r;
      jp_r   <= jp_nxt;

      ok8_r  <= ok7_r;
      n8_r   <= n7_r;
      i8_r   <= i7_r;
      l2_8_r <= l2_7_r;
      j8_r   <= j8_nxt;
    end
  end

endmodule

// ===== rtl/jdc_time.sv =====
// Day fraction to hour, minute and second, rounded to the nearest second.
`timescale 1ns / 1ps

module jdc_time (
  input  logic                clk,
  input  logic                en,
  input  jdc_pkg::jdc_front_t front,
  output jdc_pkg::jdc_tod_t   tod
);
  import jdc_pkg::*;

  logic [TP_W-1:0]    tp_r, tp_nxt;
  logic [SECS_W-1:0]  secs_r, secs_nxt;
  logic [MPROD_W-1:0] mprod_r, mprod_nxt;
  logic [MINS_W-1:0]  m_r, m_nxt;
  logic [SEC_W-1:0]   sec4_r, sec4_nxt;
  logic [HPROD_W-1:0] hp_r, hp_nxt;
  logic [HOUR_W-1:0]  h;
  jdc_tod_t           tod5_r, tod5_nxt;
  jdc_tod_t           tod6_r;
  jdc_tod_t           tod7_r;
  jdc_tod_t           tod8_r;

  // Half a second is added before the product is cut down to whole seconds.
  always_comb begin
    tp_nxt    = TP_W'(front.frac) * TP_W'(C_SEC_MUL) + (TP_W'(1) << (FRAC_BITS - 8));

    secs_nxt  = tp_r[FRAC_BITS+9:FRAC_BITS-7];
    mprod_nxt = MPROD_W'(secs_nxt) * MPROD_W'(C_SEC_RECIP);

    m_nxt     = mprod_r[C_SEC_SHIFT +: MINS_W];
    sec4_nxt  = SEC_W'(secs_r - SECS_W'(m_nxt) * SECS_W'(C_SIXTY));
    hp_nxt    = HPROD_W'(m_nxt) * HPROD_W'(C_MIN_RECIP);

    h               = hp_r[C_MIN_SHIFT +: HOUR_W];
    tod5_nxt.hour   = h;
    tod5_nxt.minute = MIN_W'(m_r - MINS_W'(h) * MINS_W'(C_SIXTY));
    tod5_nxt.second = sec4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tp_r    <= tp_nxt;
      secs_r  <= secs_nxt;
      mprod_r <= mprod_nxt;
      m_r     <= m_nxt;
      sec4_r  <= sec4_nxt;
      hp_r    <= hp_nxt;
      tod5_r  <= tod5_nxt;
      tod6_r  <= tod5_r;
      tod7_r  <= tod6_r;
      tod8_r  <= tod7_r;
    end
  end

  assign tod = tod8_r;

endmodule

// ===== rtl/julian_date_to_calendar_top.sv =====
// Top level of the Julian date to Gregorian calendar date and time converter.
//
// Usage: the input channel (in_valid, in_ready, in_julian_date) takes one Julian date
// per transfer, unsigned fixed point with FRAC_BITS fraction bits. Each input gives
// exactly one result on the output channel (out_valid, out_ready and the out_ fields):
// out_ok, the Gregorian year (astronomical numbering), month, day of month, and the
// time of day rounded to the nearest second. Hour 24 appears when the fraction rounds
// up to a full day. A whole day beyond 2147483647 gives out_ok low and all fields zero.
//
// A transfer runs through the input register, stages 1 to 8 and the output register.
// The converter takes one transfer per cycle unless the output stalls: a ten-register
// pipeline in which a stage holds at most one constant-reciprocal multiply per path.
//
// Reset (rst_n low, synchronous) empties the pipeline and the output register.
// When the receiver stalls, the result holds in the output register and the pipeline
// keeps accepting items until its last stage is full; then in_ready falls.
`timescale 1ns / 1ps

module julian_date_to_calendar_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [jdc_pkg::JD_W-1:0]         in_julian_date,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_ok,
  output logic signed [jdc_pkg::YEAR_W-1:0] out_year,
  output logic [jdc_pkg::MONTH_W-1:0]      out_month,
  output logic [jdc_pkg::DAY_W-1:0]        out_day_of_month,
  output logic [jdc_pkg::HOUR_W-1:0]       out_hour,
  output logic [jdc_pkg::MIN_W-1:0]        out_minute,
  output logic [jdc_pkg::SEC_W-1:0]        out_second
);
  import jdc_pkg::*;

  logic [LAST_STAGE:0] vld_r;
  logic                out_valid_r, out_valid_nxt;
  logic                en;
  logic                load;
  jdc_front_t          front;
  jdc_date_t           date;
  jdc_tod_t            tod;
  jdc_date_t           date_r, date_nxt;
  jdc_tod_t            tod_r, tod_nxt;

  jdc_front u_front (
    .clk         (clk),
    .en          (en),
    .julian_date (in_julian_date),
    .front       (front)
  );

  jdc_date u_date (
    .clk   (clk),
    .en    (en),
    .front (front),
    .date  (date)
  );

  jdc_time u_time (
    .clk   (clk),
    .en    (en),
    .front (front),
    .tod   (tod)
  );

  // The whole pipeline moves together unless the last stage is blocked by a held result.
  always_comb begin
    en       = !(vld_r[LAST_STAGE] && out_valid_r && !out_ready);
    in_ready = en;
    load     = en && vld_r[LAST_STAGE];
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    if (date.ok) begin
      date_nxt = date;
      tod_nxt  = tod;
    end else begin
      date_nxt = '0;
      tod_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[LAST_STAGE-1:0], in_valid};
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      date_r <= date_nxt;
      tod_r  <= tod_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = date_r.ok;
  assign out_year         = date_r.year;
  assign out_month        = date_r.month;
  assign out_day_of_month = date_r.day;
  assign out_hour         = tod_r.hour;
  assign out_minute       = tod_r.minute;
  assign out_second       = tod_r.second;

  // The input side only stalls behind a result that the receiver is holding off.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled result");

  // A rejected day number carries no date or time.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_year == '0 && out_month == '0 &&
      out_day_of_month == '0 && out_hour == '0 && out_minute == '0 && out_second == '0))
    else $error("rejected result has non-zero fields");

  // A converted date has a month from 1 to 12 and a day of month from 1 to 31.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ok) |-> (out_month >= 4'd1 && out_month <= 4'd12 &&
      out_day_of_month >= 5'd1 && out_day_of_month <= 5'd31))
    else $error("converted month or day out of range");

  // Minutes and seconds stay below sixty, and hour 24 only comes from a rounding carry.
  a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_minute < 6'd60 && out_second < 6'd60 && out_hour <= 5'd24 &&
      (out_hour != 5'd24 || (out_minute == '0 && out_second == '0))))
    else $error("time of day out of range");

endmodule
